@@ hw/rtl/md5_pkg.sv @@
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables for the MD5 hash engine.
// ----------------------------------------------------------------------------
package md5_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [31:0] PAD_BYTE = 32'h00000080;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_FIN,
    ST_PAD,
    ST_OUT
  } md5_state_e;

  // control from controller to datapath
  typedef struct packed {
    logic       load_word;   // write in_word at word position
    logic       load_pad;    // write a padding word at word position
    logic       pad_mark;    // padding word is the 0x80 marker word
    logic       pad_len;     // padding word is a length word
    logic       start;       // latch working registers from chaining words
    logic       step;        // run one compression step
    logic       finish;      // add working registers into chaining words
    logic       clear;       // restore initial values, reset counters
  } md5_cmd_t;

  typedef struct packed {
    logic       tail_whole;  // incoming word carries four or more valid bytes
    logic       step_last;   // step counter at 63
    logic [3:0] word_pos;
  } md5_status_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  valid_bytes;
    logic        is_last;
  } md5_in_t;

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_rot(input logic [5:0] i);
    logic [4:0] r;
    case ({i[5:4], i[1:0]})
      4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
      4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
      4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/md5_datapath.sv @@
// ----------------------------------------------------------------------------
// md5_datapath
// Block buffer, byte counter, chaining words and the one-step MD5 round unit.
// ----------------------------------------------------------------------------
module md5_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  md5_pkg::md5_cmd_t   cmd_i,
  input  md5_pkg::md5_in_t    in_i,
  output md5_pkg::md5_status_t status_o,
  output logic [127:0]        digest_o
);
  import md5_pkg::*;

  logic [31:0] buf_q [16];
  logic [3:0]  pos_q, pos_d;
  logic [60:0] cnt_q, cnt_d;
  logic [5:0]  step_q;
  logic [31:0] h_q [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] wr_word, pad_word, f, sum, rot;
  logic [3:0]  g;
  logic [2:0]  vb;
  logic [63:0] bits;

  // padded last word (valid below four), or marker / length / zero padding
  always_comb begin
    vb = (in_i.valid_bytes > 3'd4) ? 3'd4 : in_i.valid_bytes;
    case (vb)
      3'd0: wr_word = PAD_BYTE;
      3'd1: wr_word = {16'h0, PAD_BYTE[7:0], in_i.word[7:0]};
      3'd2: wr_word = {8'h0, PAD_BYTE[7:0], in_i.word[15:0]};
      3'd3: wr_word = {PAD_BYTE[7:0], in_i.word[23:0]};
      default: wr_word = in_i.word;
    endcase
    bits = {cnt_q, 3'b000};
    if (cmd_i.pad_mark) begin
      pad_word = PAD_BYTE;
    end else if (cmd_i.pad_len) begin
      pad_word = (pos_q == 4'd15) ? bits[63:32] : bits[31:0];
    end else begin
      pad_word = '0;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    pos_d = pos_q;
    if (cmd_i.load_word) begin
      cnt_d = in_i.is_last ? cnt_q + 61'(vb) : cnt_q + 61'd4;
      pos_d = pos_q + 4'd1;
    end else if (cmd_i.load_pad) begin
      pos_d = pos_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_word) begin
      buf_q[pos_q] <= in_i.is_last ? wr_word : in_i.word;
    end else if (cmd_i.load_pad) begin
      buf_q[pos_q] <= pad_word;
    end
  end

  always_comb begin
    case (step_q[5:4])
      2'd0: begin f = (b_q & c_q) | (~b_q & d_q); g = step_q[3:0]; end
      2'd1: begin f = (b_q & d_q) | (c_q & ~d_q); g = 4'(5 * step_q + 1); end
      2'd2: begin f = b_q ^ c_q ^ d_q;           g = 4'(3 * step_q + 5); end
      default: begin f = c_q ^ (b_q | ~d_q);     g = 4'(7 * step_q); end
    endcase
    sum = a_q + f + md5_k(step_q) + buf_q[g];
    rot = (sum << md5_rot(step_q)) | (sum >> (6'd32 - {1'b0, md5_rot(step_q)}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      cnt_q  <= '0;
      step_q <= '0;
      h_q[0] <= IV_A; h_q[1] <= IV_B; h_q[2] <= IV_C; h_q[3] <= IV_D;
    end else begin
      if (cmd_i.clear) begin
        pos_q  <= '0;
        cnt_q  <= '0;
        h_q[0] <= IV_A; h_q[1] <= IV_B; h_q[2] <= IV_C; h_q[3] <= IV_D;
      end else begin
        pos_q <= pos_d;
        cnt_q <= cnt_d;
        if (cmd_i.finish) begin
          h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
          h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
        end
      end
      if (cmd_i.start) begin
        step_q <= '0;
      end else if (cmd_i.step) begin
        step_q <= step_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
    end else if (cmd_i.step) begin
      a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= b_q + rot;
    end
  end

  assign status_o.tail_whole = vb == 3'd4;
  assign status_o.step_last  = step_q == 6'd63;
  assign status_o.word_pos   = pos_q;
  assign digest_o = {h_q[3], h_q[2], h_q[1], h_q[0]};

endmodule

@@ hw/rtl/md5_ctrl.sv @@
// ----------------------------------------------------------------------------
// md5_ctrl
// Sequencer: word intake, block compression, padding and digest hand-off.
// ----------------------------------------------------------------------------
module md5_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_fire_i,
  input  logic                 in_last_i,
  input  logic                 out_ready_i,
  input  md5_pkg::md5_status_t status_i,
  output md5_pkg::md5_cmd_t    cmd_o,
  output logic                 in_ready_o,
  output logic                 out_valid_o
);
  import md5_pkg::*;

  md5_state_e state_q, state_d;
  logic       pad_q, pad_d;     // padding run in progress
  logic       mark_q, mark_d;   // 0x80 marker word still owed
  logic       len_q, len_d;     // length field under way
  logic       begun_q, begun_d; // compression started (start issued)

  always_comb begin
    state_d = state_q;
    pad_d   = pad_q;
    mark_d  = mark_q;
    len_d   = len_q;
    begun_d = begun_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire_i) begin
          pad_d  = in_last_i;
          mark_d = in_last_i && status_i.tail_whole;
          if (status_i.word_pos == 4'd15) begin
            state_d = ST_COMP;
          end else if (in_last_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_COMP: begin
        if (!begun_q) begin
          begun_d = 1'b1;
        end else if (status_i.step_last) begin
          begun_d = 1'b0;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        state_d = !pad_q ? ST_IDLE : (len_q ? ST_OUT : ST_PAD);
      end
      ST_PAD: begin
        if (mark_q) begin
          mark_d = 1'b0;
        end else if (status_i.word_pos == 4'd14) begin
          len_d = 1'b1;
        end
        if (status_i.word_pos == 4'd15) begin
          state_d = ST_COMP;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
          pad_d   = 1'b0;
          mark_d  = 1'b0;
          len_d   = 1'b0;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_word = in_fire_i;
      end
      ST_COMP: begin
        cmd_o.start = !begun_q;
        cmd_o.step  = begun_q;
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
      end
      ST_PAD: begin
        cmd_o.load_pad = 1'b1;
        cmd_o.pad_mark = mark_q;
        cmd_o.pad_len  = !mark_q && (status_i.word_pos == 4'd14 ||
                                     (status_i.word_pos == 4'd15 && len_q));
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        cmd_o.clear = out_ready_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pad_q   <= 1'b0;
      mark_q  <= 1'b0;
      len_q   <= 1'b0;
      begun_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pad_q   <= pad_d;
      mark_q  <= mark_d;
      len_q   <= len_d;
      begun_q <= begun_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i |-> state_q == ST_IDLE)
    else $error("word taken outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step && status_i.step_last |=> cmd_o.finish)
    else $error("no finish after last step");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("digest dropped");

endmodule

@@ hw/rtl/md5_hash_engine.sv @@
// ----------------------------------------------------------------------------
// md5_hash_engine
// MD5 digest of a word stream; emits the four chaining words per message.
// ----------------------------------------------------------------------------
// Words are accepted only while idle; a full block then runs on the shared step
// unit (load, 64 round steps at one per cycle, add), and no word is taken then.
// After the last word, the padding writes and any extra block run before the
// digest is valid.
// Reset: asynchronous; chaining words to the MD5 initial values, counters zero.
module md5_hash_engine (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,   // message_word[31:0], valid_bytes[34:32]
  input  logic         s_axis_tlast,   // is_last
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // digest_a, digest_b, digest_c, digest_d
);
  import md5_pkg::*;

  md5_cmd_t    cmd;
  md5_status_t status;
  md5_in_t     in_w;

  assign in_w.word        = s_axis_tdata[31:0];
  assign in_w.valid_bytes = s_axis_tdata[34:32];
  assign in_w.is_last     = s_axis_tlast;

  md5_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i(s_axis_tvalid && s_axis_tready),
    .in_last_i(s_axis_tlast),
    .out_ready_i(m_axis_tready),
    .status_i(status),
    .cmd_o(cmd),
    .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid)
  );

  md5_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd),
    .in_i(in_w),
    .status_o(status),
    .digest_o(m_axis_tdata)
  );

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_hash_engine testbench
// Streams messages of varied length and tail size into the engine, predicts
// each MD5 digest in a local model and compares the digest transactions.
// ----------------------------------------------------------------------------
module testbench;
  import md5_pkg::*;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        last;
    logic        has_exp;
    logic [127:0] exp;
  } stim_row_t;

  localparam int unsigned CYCLE_LIMIT = 2000000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;

  logic [31:0]  chain [4];
  logic [31:0]  blk [16];
  int unsigned  wpos;
  logic [60:0]  nbyte_cnt;
  logic [127:0] digest_q [$];
  int unsigned  errors;
  int unsigned  cycles;
  bit           rx_idle_en;
  bit           tx_idle_en;
  stim_row_t    rows [$];

  md5_hash_engine i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [31:0] sine_const(int i);
    real s;
    s = $sin(real'(i + 1));
    if (s < 0.0) s = -s;
    return 32'(longint'($floor(s * 4294967296.0)));
  endfunction

  function automatic int rot_amt(int i);
    int r [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    return r[((i >> 4) << 2) | (i & 3)];
  endfunction

  task automatic md5_compress();
    logic [31:0] a, b, c, d, f, t, s;
    int g;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int i = 0; i < 64; i++) begin
      case (i >> 4)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) & 15; end
        2: begin f = b ^ c ^ d; g = (3 * i + 5) & 15; end
        default: begin f = c ^ (b | ~d); g = (7 * i) & 15; end
      endcase
      s = a + f + sine_const(i) + blk[g];
      t = d; d = c; c = b;
      b = b + ((s << rot_amt(i)) | (s >> (32 - rot_amt(i))));
      a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  task automatic append_word(logic [31:0] w);
    blk[wpos] = w;
    wpos++;
    if (wpos == 16) begin
      md5_compress();
      wpos = 0;
    end
  endtask

  task automatic md5_restart();
    chain = '{IV_A, IV_B, IV_C, IV_D};
    wpos = 0;
    nbyte_cnt = '0;
  endtask

  // returns 1 and the digest when the word closes a message
  task automatic md5_absorb(input logic [31:0] w, input logic [2:0] nb, input logic last,
                            output bit done, output logic [127:0] dig);
    int unsigned v;
    logic [63:0] bits;
    done = 0;
    dig = '0;
    if (!last) begin
      nbyte_cnt += 61'd4;
      append_word(w);
      return;
    end
    v = (nb > 4) ? 4 : nb;
    nbyte_cnt += 61'(v);
    if (v == 4) begin
      append_word(w);
      append_word(PAD_BYTE);
    end else begin
      append_word((v == 0 ? 32'h0 : (w & (32'hffffffff >> (32 - 8 * v)))) | (PAD_BYTE << (8 * v)));
    end
    if (wpos > 14) while (wpos != 0) append_word('0);
    while (wpos < 14) append_word('0);
    bits = {nbyte_cnt, 3'b000};
    append_word(bits[31:0]);
    append_word(bits[63:32]);
    dig = {chain[3], chain[2], chain[1], chain[0]};
    done = 1;
    md5_restart();
  endtask

  task automatic send_word(stim_row_t r);
    bit done;
    logic [127:0] dig;
    while (tx_idle_en && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, r.nbytes, r.word};
    s_axis_tlast  <= r.last;
    do @(posedge clk_i); while (!s_axis_tready);
    md5_absorb(r.word, r.nbytes, r.last, done, dig);
    if (done) begin
      if (r.has_exp && dig !== r.exp) begin
        $display("%0t: table digest %h, model gives %h", $time, r.exp, dig);
        errors++;
      end
      digest_q.push_back(r.has_exp ? r.exp : dig);
    end
    @(negedge clk_i);
  endtask

  task automatic send_message(int nwords, logic [2:0] tail);
    stim_row_t r;
    r.has_exp = 0;
    for (int i = 0; i < nwords; i++) begin
      r.word = $urandom();
      r.last = (i == nwords - 1);
      r.nbytes = r.last ? tail : 3'($urandom_range(7));
      send_word(r);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest %h", $time, m_axis_tdata);
        errors++;
      end else begin
        logic [127:0] e;
        e = digest_q.pop_front();
        for (int k = 0; k < 4; k++)
          if (m_axis_tdata[32*k +: 32] !== e[32*k +: 32]) begin
            $display("%0t: digest word %0d expected %h actual %h", $time, k,
                     e[32*k +: 32], m_axis_tdata[32*k +: 32]);
            errors++;
          end
      end
    end
  end

  always @(negedge clk_i)
    m_axis_tready <= rx_idle_en ? ($urandom_range(99) >= 23) : 1'b1;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("md5_hash_engine: mismatch");
      $finish;
    end
  end

  initial begin
    int n;
    errors = 0;
    cycles = 0;
    rx_idle_en = 1;
    tx_idle_en = 1;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    md5_restart();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty message, "a", "abc", all-ones tails, extra-block paddings
    rows.push_back('{32'hffffffff, 3'd0, 1'b1, 1'b1,
                     {32'h7e42f8ec, 32'h980980e9, 32'h04b2008f, 32'hd98c1dd4}});
    rows.push_back('{32'h00000061, 3'd1, 1'b1, 1'b1,
                     {32'h61267769, 32'he299c331, 32'ha8b6f1c0, 32'hb975c10c}});
    rows.push_back('{32'h00636261, 3'd3, 1'b1, 1'b1,
                     {32'h727fe128, 32'h7d3f96d6, 32'hb04fd23c, 32'h98500190}});
    rows.push_back('{32'hffffffff, 3'd4, 1'b1, 1'b0, '0});
    rows.push_back('{32'hffffffff, 3'd7, 1'b1, 1'b0, '0});
    rows.push_back('{32'h00000000, 3'd5, 1'b1, 1'b0, '0});
    rows.push_back('{32'h80000000, 3'd2, 1'b1, 1'b0, '0});
    for (int i = 0; i < 14; i++)
      rows.push_back('{32'($urandom()), 3'(i & 7), 1'b0, 1'b0, '0});
    rows.push_back('{32'hdeadbeef, 3'd4, 1'b1, 1'b0, '0});
    foreach (rows[i]) send_word(rows[i]);

    // boundary lengths around one block (13 to 17 words), giving one or two blocks
    for (int nw = 13; nw <= 17; nw++)
      for (int t = 0; t <= 4; t++) send_message(nw, 3'(t));

    // hold until every digest has drained
    s_axis_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(negedge clk_i);

    rx_idle_en = 0;
    tx_idle_en = 0;
    n = 0;
    while (n < 1000) begin
      int len;
      if (n > 300) begin
        rx_idle_en = 1;
        tx_idle_en = 1;
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(33, 70) : $urandom_range(1, 20);
      send_message(len, 3'($urandom_range(7)));
      n += len;
    end

    s_axis_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (errors == 0) begin
      $display("md5_hash_engine: match");
    end else begin
      $display("md5_hash_engine: mismatch");
    end
    $finish;
  end

endmodule
